FILE: rtl/stt_pkg.sv
// Shared constants for the spaces-to-tabs converter.
// Character codes, register map and default sizes; no dependencies.
`default_nettype none
package stt_pkg;

  // Largest supported tab stop distance (default of the top-level parameter)
  localparam int MAX_TAB_SIZE = 16;

  // Queue depth between front and back ends (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register map
  localparam logic REG_TAB_SIZE = 1'b0;
  localparam logic [4:0] TAB_SIZE_RESET = 5'd4;

  // Run tracking codes
  localparam logic [1:0] RUN_NONE   = 2'd0;
  localparam logic [1:0] RUN_SINGLE = 2'd1;
  localparam logic [1:0] RUN_MULTI  = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/stt_front.sv
// Front end: accepts text bytes, tracks column and space runs, and issues
// emit commands {filler count, filler is tab, final byte}. Uses stt_pkg.
`default_nettype none
module stt_front #(
  parameter int MAX_TAB_SIZE = stt_pkg::MAX_TAB_SIZE,
  parameter int PW = $clog2(MAX_TAB_SIZE),
  parameter int CMD_W = PW + 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [4:0]       tab_size,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output logic [CMD_W-1:0]      cmd_data
);

  localparam int CW = (PW + 1 > 5) ? PW + 1 : 5;

  logic [PW-1:0] column_phase, column_phase_next;
  logic [1:0]    run_kind, run_kind_next;
  logic [PW-1:0] held_spaces, held_spaces_next;

  logic [CW-1:0] tab_eff;
  logic [CW-1:0] phase_inc;
  logic          wrap;
  logic [PW-1:0] phase_adv;
  logic          has_cmd;
  logic [PW-1:0] fill_cnt;
  logic          fill_tab;
  logic [7:0]    final_byte;
  logic [1:0]    tabs;
  logic [PW-1:0] h;
  logic          accept;

  // Effective tab size, clamped to 1..MAX_TAB_SIZE
  always_comb begin
    tab_eff = CW'(tab_size);
    if (tab_eff == '0) tab_eff = CW'(1);
    if (tab_eff > CW'(MAX_TAB_SIZE)) tab_eff = CW'(MAX_TAB_SIZE);
  end

  // Column advance by one with wrap at the stop
  assign phase_inc = CW'(column_phase) + CW'(1);
  assign wrap      = (phase_inc >= tab_eff);
  assign phase_adv = wrap ? '0 : phase_inc[PW-1:0];

  // Classify the byte and work out the next state
  always_comb begin
    column_phase_next = column_phase;
    run_kind_next     = run_kind;
    held_spaces_next  = held_spaces;
    has_cmd    = 1'b0;
    fill_cnt   = '0;
    fill_tab   = 1'b0;
    final_byte = in_byte;
    tabs       = 2'd0;
    h          = held_spaces;
    if (in_byte == stt_pkg::CH_SPACE) begin
      if (run_kind == stt_pkg::RUN_NONE) begin
        column_phase_next = phase_adv;
        run_kind_next     = stt_pkg::RUN_SINGLE;
        held_spaces_next  = PW'(1);
      end else begin
        // second space of a run settles a stop reached by the first
        if (run_kind == stt_pkg::RUN_SINGLE && column_phase == '0) begin
          tabs = tabs + 2'd1;
          h    = '0;
        end
        run_kind_next     = stt_pkg::RUN_MULTI;
        column_phase_next = phase_adv;
        if (wrap) begin
          tabs = tabs + 2'd1;
          h    = '0;
        end else if (h < PW'(MAX_TAB_SIZE - 1)) begin
          h = h + PW'(1);
        end
        held_spaces_next = h;
        has_cmd    = (tabs != 2'd0);
        fill_cnt   = PW'(tabs - 2'd1);
        fill_tab   = 1'b1;
        final_byte = stt_pkg::CH_TAB;
      end
    end else begin
      // flush held spaces, then the byte itself
      has_cmd          = 1'b1;
      fill_cnt         = held_spaces;
      fill_tab         = 1'b0;
      final_byte       = in_byte;
      held_spaces_next = '0;
      run_kind_next    = stt_pkg::RUN_NONE;
      if (in_byte == stt_pkg::CH_NUL || in_byte == stt_pkg::CH_NL ||
          in_byte == stt_pkg::CH_TAB) begin
        column_phase_next = '0;
      end else begin
        column_phase_next = phase_adv;
      end
    end
  end

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = accept && has_cmd;
  assign cmd_data  = {fill_cnt, fill_tab, final_byte};

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_phase <= '0;
      run_kind     <= stt_pkg::RUN_NONE;
      held_spaces  <= '0;
    end else if (accept) begin
      column_phase <= column_phase_next;
      run_kind     <= run_kind_next;
      held_spaces  <= held_spaces_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stt_queue.sv
// Small command queue between the front and back ends.
// Register-based circular buffer; uses stt_pkg for its default depth.
`default_nettype none
module stt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign not_full  = (count != NW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stt_back.sv
// Back end: expands the command at the queue head into output words,
// one per cycle while the receiver takes them, into a registered output stage. Uses stt_pkg.
`default_nettype none
module stt_back #(
  parameter int MAX_TAB_SIZE = stt_pkg::MAX_TAB_SIZE,
  parameter int PW = $clog2(MAX_TAB_SIZE),
  parameter int CMD_W = PW + 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire logic [CMD_W-1:0] cmd_data,
  output logic                  cmd_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  last
);

  logic [PW-1:0] fill_cnt;
  logic          fill_tab;
  logic [7:0]    final_byte;
  logic [PW-1:0] done_cnt;
  logic          advance;
  logic          at_final;

  assign {fill_cnt, fill_tab, final_byte} = cmd_data;

  assign advance  = cmd_valid && (!out_valid || out_ready);
  assign at_final = (done_cnt == fill_cnt);
  assign cmd_pop  = advance && at_final;

  // Filler counter for the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      done_cnt <= '0;
    end else if (advance) begin
      done_cnt <= at_final ? '0 : done_cnt + PW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= at_final ? final_byte
                           : (fill_tab ? stt_pkg::CH_TAB : stt_pkg::CH_SPACE);
      last     <= at_final;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spaces_to_tabs_converter.sv
// Spaces-to-tabs converter: top level with APB register and the
// front end, command queue and back end. Uses stt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one text byte per word.
//   Output channel (out_valid/out_ready/out_byte/last) gives converted words;
//   last marks the final word caused by one input byte. A space that reaches
//   no stop causes no output word.
//   Register tab_size (byte address 0) sets the stop distance; write it only
//   while the block is idle. Reads return the stored 5-bit value.
// Throughput: one input word per cycle as long as each byte causes at most
//   one output word and the receiver does not stall. The back end emits one word per
//   cycle while not stalled, so a byte that flushes k held spaces gives it k+1 words;
//   the front end stalls once the two-entry command queue is full.
// Path: the first output word of a byte goes through the command queue,
//   written at the edge that accepts the byte, and then the output register,
//   from which it is offered on out_byte.
// Reset (rst, synchronous): clears column, run and held-space state, empties
//   the queue and output stage, and sets tab_size to 4.
// Receiver stall: the output word holds; the queue fills, then in_ready drops.
`default_nettype none
module spaces_to_tabs_converter #(
  parameter int MAX_TAB_SIZE = stt_pkg::MAX_TAB_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  // output words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last
);

  localparam int PW = $clog2(MAX_TAB_SIZE);
  localparam int CMD_W = PW + 9;

  logic [4:0]       tab_size;
  logic             cmd_valid;
  logic             q_not_full;
  logic [CMD_W-1:0] cmd_data;
  logic             q_not_empty;
  logic [CMD_W-1:0] q_head;
  logic             q_pop;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == stt_pkg::REG_TAB_SIZE) ? {27'd0, tab_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_size <= stt_pkg::TAB_SIZE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == stt_pkg::REG_TAB_SIZE) begin
      tab_size <= pwdata[4:0];
    end
  end

  stt_front #(
    .MAX_TAB_SIZE(MAX_TAB_SIZE),
    .PW(PW),
    .CMD_W(CMD_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .tab_size (tab_size),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .cmd_valid(cmd_valid),
    .cmd_ready(q_not_full),
    .cmd_data (cmd_data)
  );

  stt_queue #(
    .WIDTH(CMD_W),
    .DEPTH(stt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_data(cmd_data),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  stt_back #(
    .MAX_TAB_SIZE(MAX_TAB_SIZE),
    .PW(PW),
    .CMD_W(CMD_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_not_empty),
    .cmd_data (q_head),
    .cmd_pop  (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule
`default_nettype wire

FILE: sim/spaces_to_tabs_converter_tb.sv
// Testbench for spaces_to_tabs_converter: random and directed text through the
// byte stream, checked word by word against a built-in unexpand predictor.
// Depends on stt_pkg and the spaces_to_tabs_converter RTL only.
`default_nettype none
module spaces_to_tabs_converter_tb;

  localparam int STUCK_LIMIT = 2000;  // cycles without any accepted word
  localparam int HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int PHASE_BYTES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  // handshake bookkeeping
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int          send_gap = 0;
  int          sink_wait = 0;
  int          hold_left = 0;
  int          stall_reqs = 0;
  int          stalls_seen = 0;
  bit          no_idle = 1'b0;
  int          stuck_cycles = 0;
  int          mismatches = 0;

  // text bytes waiting to be sent and converted words still to come
  logic [7:0] text_in [$];
  out_word_t  expected_words [$];

  // converter state as the predictor sees it
  logic [4:0] tab_reg = stt_pkg::TAB_SIZE_RESET;
  logic [3:0] col_phase = '0;
  logic [1:0] run_state = stt_pkg::RUN_NONE;
  logic [3:0] held_cnt = '0;

  spaces_to_tabs_converter dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // advance the column by one; true when a tab stop is reached
  function automatic bit step_column(input int stop);
    int p;
    p = int'(col_phase) + 1;
    if (p >= stop) p = 0;
    col_phase = p[3:0];
    return p == 0;
  endfunction

  // expected words for one accepted text byte
  function automatic void unexpand_byte(input logic [7:0] b);
    int stop;
    int first;
    first = expected_words.size();
    if (tab_reg == 5'd0) stop = 1;
    else if (int'(tab_reg) > stt_pkg::MAX_TAB_SIZE) stop = stt_pkg::MAX_TAB_SIZE;
    else stop = int'(tab_reg);

    if (b == stt_pkg::CH_SPACE) begin
      if (run_state == stt_pkg::RUN_NONE) begin
        void'(step_column(stop));
        run_state = stt_pkg::RUN_SINGLE;
        held_cnt = 4'd1;
      end else begin
        // second space: a stop already reached by the first one becomes a tab
        if (run_state == stt_pkg::RUN_SINGLE) begin
          if (col_phase == 4'd0) begin
            expected_words.push_back('{stt_pkg::CH_TAB, 1'b0});
            held_cnt = 4'd0;
          end
          run_state = stt_pkg::RUN_MULTI;
        end
        if (step_column(stop)) begin
          expected_words.push_back('{stt_pkg::CH_TAB, 1'b0});
          held_cnt = 4'd0;
        end else if (int'(held_cnt) < stt_pkg::MAX_TAB_SIZE - 1) begin
          held_cnt = held_cnt + 4'd1;
        end
      end
    end else begin
      // any other byte flushes held spaces, then passes through
      repeat (held_cnt) expected_words.push_back('{stt_pkg::CH_SPACE, 1'b0});
      held_cnt = 4'd0;
      run_state = stt_pkg::RUN_NONE;
      expected_words.push_back('{b, 1'b0});
      if (b == stt_pkg::CH_NUL || b == stt_pkg::CH_NL || b == stt_pkg::CH_TAB)
        col_phase = 4'd0;
      else
        void'(step_column(stop));
    end
    if (expected_words.size() > first)
      expected_words[expected_words.size() - 1].is_last = 1'b1;
  endfunction

  // random text: mostly space runs and printable bytes, some control and noise
  function automatic void queue_text(input int count);
    int added;
    int kind;
    int run_len;
    logic [7:0] b;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 5);
        repeat (run_len) text_in.push_back(stt_pkg::CH_SPACE);
        added += run_len;
      end else begin
        if (kind < 70) b = 8'($urandom_range(8'h21, 8'h7E));
        else if (kind < 80) b = stt_pkg::CH_TAB;
        else if (kind < 88) b = stt_pkg::CH_NL;
        else if (kind < 92) b = stt_pkg::CH_NUL;
        else b = 8'($urandom_range(0, 255));
        text_in.push_back(b);
        added++;
      end
    end
  endfunction

  // wait until every word has been sent and every expected word has come back
  task automatic wait_drained();
    while (text_in.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read-back
  task automatic write_tab_size(input logic [4:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {stt_pkg::REG_TAB_SIZE, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tab_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(value)) begin
      $display("%0t: tab_size read expected %h actual %h", $time, 32'(value), prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender: one word at a time, random gap after each one unless no_idle is set
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (text_in.size() != 0) begin
        in_byte <= text_in.pop_front();
        in_valid <= 1'b1;
        send_gap <= no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each word unless no_idle is set, plus a long hold-off on request
  always @(negedge clk) begin : sink
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (stall_reqs != stalls_seen) begin
      stalls_seen <= stall_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      w = out_taken ? (no_idle ? 0 : $urandom_range(0, 4)) : sink_wait;
      if (w > 0) begin
        out_ready <= 1'b0;
        sink_wait <= w - 1;
      end else begin
        out_ready <= 1'b1;
        sink_wait <= 0;
      end
    end
  end

  // monitor: check output words, then predict from the accepted input word
  always @(posedge clk) begin : monitor
    out_word_t want;
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word expected none actual out_byte=%h last=%b",
                 $time, out_byte, last);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
          mismatches++;
        end
        if (last !== want.is_last) begin
          $display("%0t: last expected %b actual %b", $time, want.is_last, last);
          mismatches++;
        end
      end
    end
    if (!rst && in_valid && in_ready) unexpand_byte(in_byte);
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("spaces_to_tabs_converter_tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // main sequence
  initial begin : main
    int tab_plan [10];
    tab_plan = '{1, 16, 0, 31, 2, 8, 17, 3, 6, 4};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed text at the reset tab size of 4
    text_in = '{stt_pkg::CH_NUL, 8'hFF, "a", "b",
                stt_pkg::CH_SPACE, "c",                         // lone space at a stop
                stt_pkg::CH_SPACE, stt_pkg::CH_SPACE, "d",      // short run, no stop
                "x", "y", "z",
                stt_pkg::CH_SPACE, stt_pkg::CH_SPACE,           // first space hits the stop
                stt_pkg::CH_TAB,
                stt_pkg::CH_SPACE, stt_pkg::CH_SPACE, stt_pkg::CH_SPACE,
                stt_pkg::CH_SPACE, stt_pkg::CH_SPACE, stt_pkg::CH_NL,
                8'h80, stt_pkg::CH_SPACE, stt_pkg::CH_NUL};    // zero byte flushes
    wait_drained();

    // random phases across tab sizes, extremes and out-of-range values included
    foreach (tab_plan[i]) begin
      no_idle = (i % 4 == 2);
      write_tab_size(5'(tab_plan[i]));
      @(posedge clk);
      if (i == 1) stall_reqs++;
      queue_text(PHASE_BYTES);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("spaces_to_tabs_converter_tb: done, clean");
    end else begin
      $display("spaces_to_tabs_converter_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
